FILE: design/crfd_pkg.sv
// Package for the console report frame decoder: event kinds, framing constants,
// and the control id classification and event value functions.
// Depends on nothing.
package crfd_pkg;

   localparam logic [7:0] SYNC_BYTE  = 8'hA5;
   localparam logic [7:0] CHECK_GOOD = 8'h7F;
   localparam int         KEPT_LEN   = 7;

   localparam logic [3:0] PHASE_HUNT = 4'd0;
   localparam logic [3:0] PHASE_LAST = 4'd8;

   localparam logic [7:0] ID_NONE        = 8'h00;
   localparam logic [7:0] ID_TRANSPONDER = 8'h0E;
   localparam logic [7:0] ID_TRIM_A      = 8'h3E;
   localparam logic [7:0] ID_TRIM_B      = 8'h40;

   localparam logic [2:0] KIND_NONE    = 3'd0;
   localparam logic [2:0] KIND_BUTTON  = 3'd1;
   localparam logic [2:0] KIND_KNOB    = 3'd2;
   localparam logic [2:0] KIND_TOGGLE  = 3'd3;
   localparam logic [2:0] KIND_SWITCH  = 3'd4;
   localparam logic [2:0] KIND_SLIDER  = 3'd5;
   localparam logic [2:0] KIND_UNKNOWN = 3'd6;

   // Handed from the collector to the decoder when a beat is consumed.
   typedef struct packed {
      logic                          last;
      logic                          ok;
      logic [KEPT_LEN-1:0][7:0]      bytes;
   } frame_type;

   function automatic logic [2:0] classify(input logic [7:0] id);
      logic [2:0] kind;
      case (id)
         ID_NONE: kind = KIND_NONE;
         8'h02, 8'h04, 8'h06, 8'h08, 8'h0A, 8'h0C, ID_TRANSPONDER:
            kind = KIND_KNOB;
         8'h10, 8'h12, 8'h14, 8'h42, 8'h44, 8'h46, 8'h48, ID_TRIM_A, ID_TRIM_B:
            kind = KIND_BUTTON;
         8'h18, 8'h1A, 8'h1C, 8'h1E, 8'h20, 8'h22, 8'h24, 8'h26, 8'h28, 8'h2A,
         8'h2C, 8'h2E, 8'h30, 8'h36:
            kind = KIND_TOGGLE;
         8'h16, 8'h32, 8'h34:
            kind = KIND_SWITCH;
         8'h38, 8'h3A, 8'h3C, 8'h4A, 8'h4C:
            kind = KIND_SLIDER;
         default: kind = KIND_UNKNOWN;
      endcase
      return kind;
   endfunction

   function automatic logic [14:0] event_value_of(input logic [2:0] kind,
                                                  input logic [7:0] id,
                                                  input logic [7:0] b2,
                                                  input logic [7:0] b3);
      logic [14:0] value;
      case (kind)
         KIND_KNOB: begin
            if (id == ID_TRANSPONDER) begin
               value = {5'd0, b2[1:0], b3};
            end else begin
               // The two bytes overlap at bit 7, where they are ORed together.
               value = {b3, 7'd0} | {7'd0, b2};
            end
         end
         KIND_BUTTON: begin
            if (id == ID_TRIM_A || id == ID_TRIM_B) begin
               value = {7'd0, b2 - 8'd1};
            end else begin
               value = 15'd0;
            end
         end
         KIND_TOGGLE:               value = {14'd0, |b2};
         KIND_SWITCH, KIND_SLIDER:  value = {7'd0, b2};
         default:                   value = 15'd0;
      endcase
      return value;
   endfunction

endpackage

FILE: design/crfd_collect.sv
// Frame collector: hunts for the sync byte, keeps report bytes 0 to 6 and
// folds every report byte into the XOR check. Depends on crfd_pkg.
module crfd_collect (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic [7:0]           rx_byte,
   output crfd_pkg::frame_type  frame
);

   logic [3:0] phase_ff, phase_in;
   logic [7:0] accum_ff, accum_in;
   logic [7:0] bytes_ff [crfd_pkg::KEPT_LEN];
   logic       hunting;
   logic       storing;
   logic [3:0] phase_less;
   logic [2:0] store_idx;
   logic [7:0] accum_next;

   assign hunting    = (phase_ff == crfd_pkg::PHASE_HUNT) || (phase_ff > crfd_pkg::PHASE_LAST);
   assign storing    = !hunting && (phase_ff != crfd_pkg::PHASE_LAST);
   assign phase_less = phase_ff - 4'd1;
   assign store_idx  = phase_less[2:0];
   assign accum_next = accum_ff ^ rx_byte;

   always_comb begin
      phase_in = phase_ff;
      accum_in = accum_ff;
      if (advance) begin
         if (hunting) begin
            if (rx_byte == crfd_pkg::SYNC_BYTE) begin
               phase_in = 4'd1;
               accum_in = 8'd0;
            end else begin
               phase_in = crfd_pkg::PHASE_HUNT;
            end
         end else if (storing) begin
            phase_in = phase_ff + 4'd1;
            accum_in = accum_next;
         end else begin
            phase_in = crfd_pkg::PHASE_HUNT;
            accum_in = accum_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= crfd_pkg::PHASE_HUNT;
         accum_ff <= 8'd0;
      end else begin
         phase_ff <= phase_in;
         accum_ff <= accum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && storing) begin
         bytes_ff[store_idx] <= rx_byte;
      end
   end

   always_comb begin
      frame.last = advance && (phase_ff == crfd_pkg::PHASE_LAST);
      frame.ok   = (accum_next == crfd_pkg::CHECK_GOOD);
      for (int i = 0; i < crfd_pkg::KEPT_LEN; i++) begin
         frame.bytes[i] = bytes_ff[i];
      end
   end

   // The phase never leaves the range of a report.
   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff <= crfd_pkg::PHASE_LAST)
      else $error("byte phase out of range");

   // The eighth byte always sends the collector back to hunting.
   a_last_hunts: assert property (@(posedge clock) disable iff (reset)
      frame.last |=> phase_ff == crfd_pkg::PHASE_HUNT)
      else $error("collector did not return to hunting after a report");

endmodule

FILE: design/crfd_decode.sv
// Report decoder and result register: applies the sign flags, classifies the
// control id and holds one result beat. Depends on crfd_pkg.
module crfd_decode (
   input  logic                 clock,
   input  logic                 reset,
   input  crfd_pkg::frame_type  frame,
   output logic                 out_free,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_frame_ok,
   output logic [7:0]           rsp_roll,
   output logic [7:0]           rsp_pitch,
   output logic [7:0]           rsp_yaw,
   output logic [2:0]           rsp_event_kind,
   output logic [7:0]           rsp_event_id,
   output logic [14:0]          rsp_event_value
);

   logic        valid_ff, valid_in;
   logic        ok_ff;
   logic [7:0]  roll_ff, pitch_ff, yaw_ff, id_ff;
   logic [2:0]  kind_ff;
   logic [14:0] value_ff;

   logic [7:0]  flags, id;
   logic [2:0]  kind;
   logic [7:0]  roll_in, pitch_in, yaw_in, id_in;
   logic [2:0]  kind_in;
   logic [14:0] value_in;

   assign out_free = !valid_ff || rsp_ready;
   assign flags    = frame.bytes[0];
   assign id       = frame.bytes[4];
   assign kind     = crfd_pkg::classify(id);

   // A rejected report carries zeros in every field.
   always_comb begin
      roll_in  = 8'd0;
      pitch_in = 8'd0;
      yaw_in   = 8'd0;
      kind_in  = crfd_pkg::KIND_NONE;
      id_in    = 8'd0;
      value_in = 15'd0;
      if (frame.ok) begin
         roll_in  = flags[1] ? 8'd0 - frame.bytes[2] : frame.bytes[2];
         pitch_in = flags[0] ? 8'd0 - frame.bytes[1] : frame.bytes[1];
         yaw_in   = flags[2] ? 8'd0 - frame.bytes[3] : frame.bytes[3];
         kind_in  = kind;
         id_in    = id;
         value_in = crfd_pkg::event_value_of(kind, id, frame.bytes[5], frame.bytes[6]);
      end
   end

   always_comb begin
      if (frame.last) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (frame.last) begin
         ok_ff    <= frame.ok;
         roll_ff  <= roll_in;
         pitch_ff <= pitch_in;
         yaw_ff   <= yaw_in;
         kind_ff  <= kind_in;
         id_ff    <= id_in;
         value_ff <= value_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_frame_ok    = ok_ff;
   assign rsp_roll        = roll_ff;
   assign rsp_pitch       = pitch_ff;
   assign rsp_yaw         = yaw_ff;
   assign rsp_event_kind  = kind_ff;
   assign rsp_event_id    = id_ff;
   assign rsp_event_value = value_ff;

   // A finished report only arrives when the result register has room.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      frame.last |-> out_free)
      else $error("result beat overwritten before it was taken");

   // A rejected report shows zeros in all its fields.
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !ok_ff) |-> (roll_ff == 8'd0 && pitch_ff == 8'd0 &&
         yaw_ff == 8'd0 && kind_ff == crfd_pkg::KIND_NONE && id_ff == 8'd0 &&
         value_ff == 15'd0))
      else $error("rejected report carries non-zero fields");

endmodule

FILE: design/console_report_frame_decoder.sv
// Top level of the console report frame decoder: input register, frame collector and
// result decoder. Depends on crfd_pkg, crfd_collect and crfd_decode. The block takes
// one received serial byte per beat and can accept one beat in every cycle. A byte is
// registered on arrival and consumed by the frame collector when the result register
// has room. The check byte is the eighth after sync, and the edge that consumes it also
// loads the result register and raises rsp_valid, which is registered.
// The input register, collector and result register advance together. While a result
// beat waits in the result register and rsp_ready is low, the collector stalls on
// every byte, not only on the next check byte. The input register then holds one more
// byte and req_ready stays low until the result beat is taken.
module console_report_frame_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_frame_ok,
   output logic [7:0]  rsp_roll,
   output logic [7:0]  rsp_pitch,
   output logic [7:0]  rsp_yaw,
   output logic [2:0]  rsp_event_kind,
   output logic [7:0]  rsp_event_id,
   output logic [14:0] rsp_event_value
);

   logic                in_valid_ff, in_valid_in;
   logic [7:0]          in_byte_ff;
   logic                out_free;
   logic                advance;
   crfd_pkg::frame_type frame;

   assign advance     = in_valid_ff && out_free;
   assign req_ready   = !in_valid_ff || out_free;
   assign in_valid_in = (req_valid && req_ready) || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   crfd_collect u_collect (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .rx_byte (in_byte_ff),
      .frame   (frame)
   );

   crfd_decode u_decode (
      .clock           (clock),
      .reset           (reset),
      .frame           (frame),
      .out_free        (out_free),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_frame_ok    (rsp_frame_ok),
      .rsp_roll        (rsp_roll),
      .rsp_pitch       (rsp_pitch),
      .rsp_yaw         (rsp_yaw),
      .rsp_event_kind  (rsp_event_kind),
      .rsp_event_id    (rsp_event_id),
      .rsp_event_value (rsp_event_value)
   );

endmodule
